// ===== rtl/tak_pkg.sv =====
// ----------------------------------------------------------------------------
// tak_pkg - shared types, constants and helpers of the tilt Kalman filter
// Register indexes, reset values, multiplier request and saturation helpers.
// ----------------------------------------------------------------------------
package tak_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned AccW = 44;
  localparam int unsigned MulW = 40;
  localparam int unsigned DivW = 44;

  localparam logic [CfgIdxW-1:0] RegSamplePeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngleNoise = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBiasNoise = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMeasureNoise = 3'd3;

  localparam logic [31:0] RstSamplePeriod = 32'd4294967;
  localparam logic [30:0] RstAngleNoise = 31'd26844;
  localparam logic [30:0] RstBiasNoise = 31'd805;
  localparam logic [30:0] RstMeasureNoise = 31'd19660800;
  localparam logic signed [31:0] OneQ28 = 32'sd268435456;

  typedef struct packed {
    logic go;
    logic sh28;
  } mul_req_t;

  function automatic logic signed [AccW-1:0] ext32(input logic signed [31:0] v);
    return {{(AccW-32){v[31]}}, v};
  endfunction

  function automatic logic signed [AccW-1:0] ext40(input logic signed [MulW-1:0] v);
    return {{(AccW-MulW){v[MulW-1]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic hi;
    logic lo;
    hi = !v[AccW-1] && (v[AccW-2:31] != '0);
    lo = v[AccW-1] && (v[AccW-2:31] != '1);
    if (hi) return 32'sh7FFF_FFFF;
    else if (lo) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// ===== rtl/tak_mul.sv =====
// ----------------------------------------------------------------------------
// tak_mul - shared rounding multiplier
// Sign-magnitude 33x33 product, then shift by 28 or 32 rounding to nearest,
// ties away from zero. Two register stages.
// ----------------------------------------------------------------------------
module tak_mul
  import tak_pkg::*;
(
  input  logic                   clk,
  input  mul_req_t               req,
  input  logic signed [32:0]     a,
  input  logic signed [32:0]     b,
  output logic signed [MulW-1:0] res
);

  logic [32:0] amag;
  logic [32:0] bmag;
  logic [65:0] prod;
  logic        neg;
  logic        sh28;
  logic [66:0] rnd;
  logic [MulW-1:0] mag;

  assign amag = a[32] ? 33'(-a) : 33'(a);
  assign bmag = b[32] ? 33'(-b) : 33'(b);

  always_comb begin
    if (sh28) begin
      rnd = {1'b0, prod} + 67'(1 << 27);
      mag = MulW'(rnd >> 28);
    end else begin
      rnd = {1'b0, prod} + 67'(64'd1 << 31);
      mag = MulW'(rnd >> 32);
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod <= amag * bmag;
      neg  <= a[32] ^ b[32];
      sh28 <= req.sh28;
    end
    res <= neg ? -$signed(mag) : $signed(mag);
  end

endmodule

// ===== rtl/tak_div.sv =====
// ----------------------------------------------------------------------------
// tak_div - two-lane restoring divider for the gains
// Divides (n << 28) by a shared divisor, two quotient bits per cycle in 30
// steps. Quotients clamp to 2^31.
// ----------------------------------------------------------------------------
module tak_div
  import tak_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DivW-1:0] divisor,
  input  logic [31:0]     num0,
  input  logic [31:0]     num1,
  output logic            busy,
  output logic            done,
  output logic [31:0]     q0,
  output logic [31:0]     q1
);

  localparam int unsigned NumW = 60;
  localparam int unsigned Steps = NumW / 2;

  logic [DivW-1:0] d;
  logic [NumW-1:0] n0, n1, qa, qb;
  logic [DivW-1:0] r0, r1;
  logic [DivW-1:0] r0_next, r1_next;
  logic [1:0]      b0, b1;
  logic [4:0]      cnt;

  function automatic logic [DivW:0] step(input logic [DivW-1:0] r, input logic nb,
                                         input logic [DivW-1:0] dv);
    logic [DivW:0] s;
    s = {r, nb};
    if (s >= {1'b0, dv}) return {1'b1, DivW'(s - {1'b0, dv})};
    else return {1'b0, s[DivW-1:0]};
  endfunction

  always_comb begin
    logic [DivW:0] t;
    t = step(r0, n0[NumW-1], d);
    b0[1] = t[DivW];
    t = step(t[DivW-1:0], n0[NumW-2], d);
    b0[0] = t[DivW];
    r0_next = t[DivW-1:0];
    t = step(r1, n1[NumW-1], d);
    b1[1] = t[DivW];
    t = step(t[DivW-1:0], n1[NumW-2], d);
    b1[0] = t[DivW];
    r1_next = t[DivW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == 5'(Steps - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        d    <= divisor;
        n0   <= {num0, 28'b0};
        n1   <= {num1, 28'b0};
        r0   <= '0;
        r1   <= '0;
        qa   <= '0;
        qb   <= '0;
      end else if (busy) begin
        n0 <= n0 << 2;
        n1 <= n1 << 2;
        r0 <= r0_next;
        r1 <= r1_next;
        qa <= {qa[NumW-3:0], b0};
        qb <= {qb[NumW-3:0], b1};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(Steps - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign q0 = (qa[NumW-1:31] != '0) ? 32'h8000_0000 : qa[31:0];
  assign q1 = (qb[NumW-1:31] != '0) ? 32'h8000_0000 : qb[31:0];

endmodule

// ===== rtl/tilt_angle_kalman_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tilt_angle_kalman_filter_unit - two-state tilt Kalman filter
// Fuses accelerometer angle and gyro rate; Q16.16 angles, Q4.28 covariance.
//
//  channel | signals                              | role
//  in      | in_valid in_ready angle_meas rate_meas | one sample per item
//  out     | out_valid out_ready angle_out rate_out | one estimate per item
//  cfg     | cfg_we cfg_index cfg_wdata           | register writes
//
// Each item makes nine passes through the shared multiplier, a run of the
// two-lane gain divider (30 steps and done, skipped when the divisor is not
// positive), and the divider start, output and accept steps.
// in_ready is high whenever the sequencer is idle.
// Synchronous reset restores register reset values and identity covariance.
// A result still waiting in the output register holds the next one in the
// output step.
// ----------------------------------------------------------------------------
module tilt_angle_kalman_filter_unit
  import tak_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   angle_meas,
  input  logic signed [31:0]   rate_meas,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   angle_out,
  output logic signed [31:0]   rate_out,
  input  logic                 cfg_we,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [31:0]          cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PRED_ANG, ST_PRED_P00, ST_PRED_P11, ST_DIV_START, ST_DIV_WAIT,
    ST_UPD_P00, ST_UPD_P01, ST_UPD_P10, ST_UPD_P11, ST_UPD_ANG, ST_UPD_BIAS,
    ST_OUT
  } state_t;

  state_t state;
  logic [1:0] ph;

  logic [31:0] dt;
  logic [30:0] anoise, bnoise, rnoise;
  logic signed [31:0] am, rm;
  logic signed [31:0] angle, bias, p00, p01, p10, p11;
  logic signed [31:0] t0, t1, k0, k1;
  logic signed [32:0] err;

  mul_req_t mreq;
  logic signed [32:0] ma, mb;
  logic signed [MulW-1:0] m;
  logic mul_state;

  logic signed [44:0] e;
  logic e_pos;
  logic div_start, div_busy, div_done;
  logic [31:0] q0, q1;

  always_comb begin
    ma = '0;
    mb = '0;
    mreq.sh28 = 1'b1;
    mul_state = 1'b1;
    unique case (state)
      ST_PRED_ANG: begin
        ma = {rm[31], rm} - {bias[31], bias};
        mb = {1'b0, dt};
        mreq.sh28 = 1'b0;
      end
      ST_PRED_P00: begin
        ma = {p01[31], p01} + {p10[31], p10};
        mb = {1'b0, dt};
        mreq.sh28 = 1'b0;
      end
      ST_PRED_P11: begin
        ma = {p11[31], p11};
        mb = {1'b0, dt};
        mreq.sh28 = 1'b0;
      end
      ST_UPD_P00: begin ma = {k0[31], k0}; mb = {t0[31], t0}; end
      ST_UPD_P01: begin ma = {k0[31], k0}; mb = {t1[31], t1}; end
      ST_UPD_P10: begin ma = {k1[31], k1}; mb = {t0[31], t0}; end
      ST_UPD_P11: begin ma = {k1[31], k1}; mb = {t1[31], t1}; end
      ST_UPD_ANG: begin ma = {k0[31], k0}; mb = err; end
      ST_UPD_BIAS: begin ma = {k1[31], k1}; mb = err; end
      default: mul_state = 1'b0;
    endcase
    mreq.go = mul_state && (ph == 2'd0);
  end

  tak_mul u_mul (
    .clk (clk),
    .req (mreq),
    .a   (ma),
    .b   (mb),
    .res (m)
  );

  assign e = $signed({2'b00, rnoise, 12'b0}) + $signed({{13{p00[31]}}, p00});
  assign e_pos = !e[44] && (e != '0);
  assign div_start = (state == ST_DIV_START) && e_pos;

  tak_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (e[DivW-1:0]),
    .num0    (p00[31] ? 32'(-p00) : 32'(p00)),
    .num1    (p10[31] ? 32'(-p10) : 32'(p10)),
    .busy    (div_busy),
    .done    (div_done),
    .q0      (q0),
    .q1      (q1)
  );

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ph        <= '0;
      out_valid <= 1'b0;
      dt        <= RstSamplePeriod;
      anoise    <= RstAngleNoise;
      bnoise    <= RstBiasNoise;
      rnoise    <= RstMeasureNoise;
      angle     <= '0;
      bias      <= '0;
      p00       <= OneQ28;
      p01       <= '0;
      p10       <= '0;
      p11       <= OneQ28;
    end else begin
      if (out_valid && out_ready && (state != ST_OUT)) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          RegSamplePeriod: dt <= cfg_wdata;
          RegAngleNoise:   anoise <= cfg_wdata[30:0];
          RegBiasNoise:    bnoise <= cfg_wdata[30:0];
          RegMeasureNoise: rnoise <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (mul_state) ph <= (ph == 2'd2) ? 2'd0 : ph + 2'd1;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            am    <= angle_meas;
            rm    <= rate_meas;
            state <= ST_PRED_ANG;
          end
        end
        ST_DIV_START: begin
          err <= {am[31], am} - {angle[31], angle};
          t0  <= p00;
          t1  <= p01;
          if (e_pos) begin
            state <= ST_DIV_WAIT;
          end else begin
            k0    <= '0;
            k1    <= '0;
            state <= ST_UPD_P00;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            k0 <= t0[31] ? 32'(-$signed(q0)) : (q0[31] ? 32'sh7FFF_FFFF : $signed(q0));
            k1 <= p10[31] ? 32'(-$signed(q1)) : (q1[31] ? 32'sh7FFF_FFFF : $signed(q1));
            state <= ST_UPD_P00;
          end
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            angle_out <= angle;
            rate_out  <= sat32(ext32(rm) - ext32(bias));
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          if (ph == 2'd2) begin
            unique case (state)
              ST_PRED_ANG: begin
                angle <= sat32(ext32(angle) + ext40(m));
                state <= ST_PRED_P00;
              end
              ST_PRED_P00: begin
                p00 <= sat32(ext32(p00) + {13'b0, anoise} - ext40(m));
                state <= ST_PRED_P11;
              end
              ST_PRED_P11: begin
                p01 <= sat32(ext32(p01) - ext40(m));
                p10 <= sat32(ext32(p10) - ext40(m));
                p11 <= sat32(ext32(p11) + {13'b0, bnoise});
                state <= ST_DIV_START;
              end
              ST_UPD_P00: begin
                p00 <= sat32(ext32(t0) - ext40(m));
                state <= ST_UPD_P01;
              end
              ST_UPD_P01: begin
                p01 <= sat32(ext32(t1) - ext40(m));
                state <= ST_UPD_P10;
              end
              ST_UPD_P10: begin
                p10 <= sat32(ext32(p10) - ext40(m));
                state <= ST_UPD_P11;
              end
              ST_UPD_P11: begin
                p11 <= sat32(ext32(p11) - ext40(m));
                state <= ST_UPD_ANG;
              end
              ST_UPD_ANG: begin
                angle <= sat32(ext32(angle) + ext40(m));
                state <= ST_UPD_BIAS;
              end
              ST_UPD_BIAS: begin
                bias  <= sat32(ext32(bias) + ext40(m));
                state <= ST_OUT;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_PRED_ANG)
    else $error("accepted item did not start the predict step");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV_WAIT)
    else $error("gain divider finished outside its wait state");

  a_div_busy_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == ST_DIV_WAIT)
    else $error("gain divider running outside its wait state");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output step");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench of the tilt angle Kalman filter unit
// A table of directed samples and register writes, then random samples in
// three idling phases. Every estimate is checked against an in-bench fixed
// point filter that tracks angle, bias, covariance and registers.
// ----------------------------------------------------------------------------
module tb_top
  import tak_pkg::*;
();

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    logic [CfgIdxW-1:0]  idx;
    logic [31:0]         wdata;
    logic signed [31:0]  am;
    logic signed [31:0]  rm;
    bit                  typed;
    logic signed [31:0]  ea;
    logic signed [31:0]  er;
  } row_t;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
  } estimate_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [31:0]  angle_meas = '0;
  logic signed [31:0]  rate_meas = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  angle_out;
  logic signed [31:0]  rate_out;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_wdata = '0;

  // filter copy
  logic [31:0]         dt_reg;
  logic [30:0]         qa_reg, qb_reg, rn_reg;
  int                  est_angle, est_bias;
  int                  cov [4];

  estimate_t           est_q [$];
  int                  n_err = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  tilt_angle_kalman_filter_unit i_dut (
    .clk, .rst, .in_valid, .in_ready, .angle_meas, .rate_meas,
    .out_valid, .out_ready, .angle_out, .rate_out,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic logic [63:0] magn(input longint v);
    logic [63:0] m;
    m = v;
    if (v < 0) m = -m;
    return m;
  endfunction

  function automatic longint mul_round(input longint a, input longint b, input int sh);
    logic [63:0] p, r;
    p = magn(a) * magn(b);
    r = (p + (64'd1 << (sh - 1))) >> sh;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic int kgain(input longint p, input longint e);
    logic [63:0] q;
    q = (magn(p) << 28) / e;
    if (q > (64'd1 << 33)) q = 64'd1 << 33;
    return sat((p < 0) ? -longint'(q) : longint'(q));
  endfunction

  function automatic void filter_reset();
    dt_reg = RstSamplePeriod;
    qa_reg = RstAngleNoise;
    qb_reg = RstBiasNoise;
    rn_reg = RstMeasureNoise;
    est_angle = 0;
    est_bias = 0;
    cov = '{OneQ28, 0, 0, OneQ28};
  endfunction

  function automatic estimate_t filter_step(input int am, input int rm);
    longint dt, p00, p01, p10, p11, dp11, e, err, t0, t1;
    int k0, k1;
    estimate_t res;
    dt = longint'({32'd0, dt_reg});
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    k0 = 0; k1 = 0;
    est_angle = sat(longint'(est_angle) + mul_round(longint'(rm) - est_bias, dt, 32));
    dp11 = mul_round(p11, dt, 32);
    cov[0] = sat(p00 + longint'(qa_reg) - mul_round(p01 + p10, dt, 32));
    cov[1] = sat(p01 - dp11);
    cov[2] = sat(p10 - dp11);
    cov[3] = sat(p11 + longint'(qb_reg));
    err = longint'(am) - est_angle;
    t0 = cov[0];
    t1 = cov[1];
    e = (longint'(rn_reg) << 12) + t0;
    if (e > 0) begin
      k0 = kgain(t0, e);
      k1 = kgain(cov[2], e);
    end
    cov[0] = sat(t0 - mul_round(k0, t0, 28));
    cov[1] = sat(t1 - mul_round(k0, t1, 28));
    cov[2] = sat(longint'(cov[2]) - mul_round(k1, t0, 28));
    cov[3] = sat(longint'(cov[3]) - mul_round(k1, t1, 28));
    est_angle = sat(longint'(est_angle) + mul_round(k0, err, 28));
    est_bias = sat(longint'(est_bias) + mul_round(k1, err, 28));
    res.angle = est_angle;
    res.rate = sat(longint'(rm) - est_bias);
    return res;
  endfunction

  // drive one sample; valid stays high after acceptance unless a gap follows
  task automatic send_sample(input int am, input int rm, input bit typed,
                             input int ea, input int er);
    estimate_t pred;
    int gap;
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    angle_meas <= am;
    rate_meas <= rm;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pred = filter_step(am, rm);
    if (typed && (pred.angle != ea || pred.rate != er)) begin
      n_err++;
      if (n_err <= 10)
        $display("typed estimate disagrees: angle %0d/%0d rate %0d/%0d",
                 ea, pred.angle, er, pred.rate);
    end
    if (typed) begin
      pred.angle = ea;
      pred.rate = er;
    end
    est_q.push_back(pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (est_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegSamplePeriod: dt_reg = d;
      RegAngleNoise:   qa_reg = d[30:0];
      RegBiasNoise:    qb_reg = d[30:0];
      RegMeasureNoise: rn_reg = d[30:0];
      default: ;
    endcase
  endtask

  task automatic random_samples(input int n);
    int base;
    int am, rm;
    base = $urandom_range(180 << 16) - (90 << 16);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        base += $urandom_range(2 << 16) - (1 << 16);
        am = base + $urandom_range(4 << 16) - (2 << 16);
        rm = $urandom_range(400 << 16) - (200 << 16);
      end else begin
        am = $urandom;
        rm = $urandom;
      end
      send_sample(am, rm, 1'b0, 0, 0);
    end
  endtask

  always @(posedge clk) begin
    estimate_t exp_est;
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && out_valid && out_ready) begin
      if (est_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("estimate with none pending: %0d %0d", angle_out, rate_out);
      end else begin
        exp_est = est_q.pop_front();
        if (angle_out !== exp_est.angle || rate_out !== exp_est.rate) begin
          n_err++;
          if (n_err <= 10)
            $display("mismatch: angle exp %0d got %0d, rate exp %0d got %0d",
                     exp_est.angle, angle_out, exp_est.rate, rate_out);
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t rows [$];
    filter_reset();
    rows = '{
      '{ROW_ITEM, 0, 0, 0, 0, 1, 0, 0},
      '{ROW_ITEM, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 10 << 16, -(5 << 16), 0, 0, 0},
      '{ROW_REG, 5, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 3 << 16, 1 << 16, 0, 0, 0},
      '{ROW_REG, RegMeasureNoise, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 45 << 16, 0, 0, 0, 0},
      '{ROW_REG, RegMeasureNoise, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, RegSamplePeriod, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{ROW_REG, RegAngleNoise, 32'h7FFF_FFFF, 0, 0, 0, 0, 0},
      '{ROW_REG, RegBiasNoise, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0},
      '{ROW_ITEM, 0, 0, -(90 << 16), 250 << 16, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, RegSamplePeriod, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, RegAngleNoise, 0, 0, 0, 0, 0, 0},
      '{ROW_REG, RegBiasNoise, 0, 0, 0, 0, 0, 0},
      '{ROW_ITEM, 0, 0, 1, -1, 0, 0, 0},
      '{ROW_ITEM, 0, 0, -1, 1, 0, 0, 0}
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) write_reg(rows[i].idx, rows[i].wdata);
      else send_sample(rows[i].am, rows[i].rm, rows[i].typed, rows[i].ea, rows[i].er);
    end

    // back to usual filter settings
    write_reg(RegSamplePeriod, RstSamplePeriod);
    write_reg(RegAngleNoise, RstAngleNoise);
    write_reg(RegBiasNoise, RstBiasNoise);
    write_reg(RegMeasureNoise, RstMeasureNoise);
    send_idle_pct = 38;
    recv_idle_pct = 47;
    random_samples(140);
    drain();
    random_samples(140);

    write_reg(RegSamplePeriod, $urandom);
    write_reg(RegAngleNoise, $urandom);
    write_reg(RegBiasNoise, $urandom_range(1 << 20));
    write_reg(RegMeasureNoise, $urandom_range(1 << 16));
    send_idle_pct = 47;
    recv_idle_pct = 38;
    random_samples(280);

    write_reg(RegSamplePeriod, 32'd4294967 * $urandom_range(5, 1));
    write_reg(RegMeasureNoise, $urandom_range(40 << 16));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_samples(270);

    drain();
    if (n_err == 0 && est_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
